[rtl/cp15_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp15_pkg
// Shared constants, register numbers and maintenance command codes for the
// system control coprocessor register file.
// ----------------------------------------------------------------------------
package cp15_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned FsrW     = 8;
  localparam int unsigned PidW     = 7;
  localparam int unsigned PidShift = 25;

  localparam logic [WordW-1:0] CtrlOnes      = 32'h0005_0078;
  localparam logic [WordW-1:0] CtrlKeep      = 32'h0005_F3FF;
  localparam logic [WordW-1:0] TtbKeep       = 32'hFFFF_C000;
  localparam logic [WordW-1:0] CacheTypeVal  = 32'h1D0D_2112;
  localparam logic [WordW-1:0] DeviceIdReset = 32'h4106_9260;
  localparam logic [WordW-1:0] DacReset      = 32'hDEAD_C0DE;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_type_t;

  typedef enum logic {
    ST_OK          = 1'b0,
    ST_UNSUPPORTED = 1'b1
  } status_t;

  typedef enum logic [3:0] {
    CREG_ID    = 4'd0,
    CREG_CTRL  = 4'd1,
    CREG_TTB   = 4'd2,
    CREG_DAC   = 4'd3,
    CREG_R4    = 4'd4,
    CREG_FSR   = 4'd5,
    CREG_FAR   = 4'd6,
    CREG_CACHE = 4'd7,
    CREG_TLB   = 4'd8,
    CREG_LOCK  = 4'd9,
    CREG_R10   = 4'd10,
    CREG_R11   = 4'd11,
    CREG_R12   = 4'd12,
    CREG_PID   = 4'd13,
    CREG_R14   = 4'd14,
    CREG_R15   = 4'd15
  } creg_t;

  typedef enum logic [3:0] {
    MOP_NONE          = 4'd0,
    MOP_INV_IDC       = 4'd1,
    MOP_INV_IC        = 4'd2,
    MOP_INV_I_MVA     = 4'd3,
    MOP_INV_I_SW      = 4'd4,
    MOP_INV_DC        = 4'd5,
    MOP_INV_D_MVA     = 4'd6,
    MOP_INV_D_SW      = 4'd7,
    MOP_CLN_D_MVA     = 4'd8,
    MOP_CLN_D_SW      = 4'd9,
    MOP_CLN_INV_D_MVA = 4'd10,
    MOP_CLN_INV_D_SW  = 4'd11,
    MOP_DRAIN_WB      = 4'd12,
    MOP_DRAIN_WFI     = 4'd13,
    MOP_TLB_INV_ALL   = 4'd14,
    MOP_TLB_INV_MVA   = 4'd15
  } maint_op_t;

endpackage

[rtl/cp15_system_control_registers_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp15_system_control_registers_core
// Coprocessor register file: decodes one MRC/MCR access per word, updates the
// control registers and returns read data, status and a maintenance command.
// ----------------------------------------------------------------------------
// One access is taken per clock while s_axis_tready is high. It is decoded
// against the stored registers in the cycle it is accepted, the registers
// update at that edge, and the result appears on the output word in the
// following cycle. The single output register lets a new access in while
// the previous result is taken, so the block sustains one access per cycle;
// s_axis_tready drops only while a result is held and m_axis_tready is low.
module cp15_system_control_registers_core
  import cp15_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] instr_word, [63:32] write_value
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] read_data, [35:32] maint_op,
                                      // [67:36] maint_operand, [71:68] zero
  output logic [0:0]  m_axis_tuser,   // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [WordW-1:0] device_id;
  logic [WordW-1:0] control_reg;
  logic [WordW-1:0] table_base_reg;
  logic [WordW-1:0] domain_access_reg;
  logic [FsrW-1:0]  fsr_reg;
  logic [WordW-1:0] fault_address_reg;
  logic [PidW-1:0]  process_id_reg;

  logic             accept;
  logic             is_write;
  logic [WordW-1:0] instr;
  logic [WordW-1:0] wval;
  creg_t            creg;
  logic [2:0]       op2;
  logic [3:0]       crm;

  logic [WordW-1:0] rdata_next;
  status_t          status_next;
  maint_op_t        mop_next;
  logic [WordW-1:0] mopnd_next;
  logic             cache_known;
  maint_op_t        cache_op;
  logic             cache_uses;
  logic             tlb_crm_ok;

  logic [WordW-1:0] read_data;
  status_t          status;
  maint_op_t        maint_op;
  logic [WordW-1:0] maint_operand;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign is_write = (s_axis_tuser[0] == REQ_WRITE);
  assign instr    = s_axis_tdata[31:0];
  assign wval     = s_axis_tdata[63:32];
  assign creg     = creg_t'(instr[19:16]);
  assign op2      = instr[7:5];
  assign crm      = instr[3:0];

  assign tlb_crm_ok = (crm == 4'd5) || (crm == 4'd6) || (crm == 4'd7);

  always_comb begin
    cache_known = 1'b1;
    cache_op    = MOP_NONE;
    cache_uses  = 1'b0;
    priority if (op2 == 3'd0 && crm == 4'd7) cache_op = MOP_INV_IDC;
    else if (op2 == 3'd0 && crm == 4'd5) cache_op = MOP_INV_IC;
    else if (op2 == 3'd1 && crm == 4'd5) begin
      cache_op = MOP_INV_I_MVA; cache_uses = 1'b1;
    end else if (op2 == 3'd2 && crm == 4'd5) begin
      cache_op = MOP_INV_I_SW; cache_uses = 1'b1;
    end else if (op2 == 3'd1 && crm == 4'd13) cache_op = MOP_NONE;
    else if (op2 == 3'd0 && crm == 4'd6) cache_op = MOP_INV_DC;
    else if (op2 == 3'd1 && crm == 4'd6) begin
      cache_op = MOP_INV_D_MVA; cache_uses = 1'b1;
    end else if (op2 == 3'd2 && crm == 4'd6) begin
      cache_op = MOP_INV_D_SW; cache_uses = 1'b1;
    end else if (op2 == 3'd1 && crm == 4'd10) begin
      cache_op = MOP_CLN_D_MVA; cache_uses = 1'b1;
    end else if (op2 == 3'd2 && crm == 4'd10) begin
      cache_op = MOP_CLN_D_SW; cache_uses = 1'b1;
    end else if (op2 == 3'd3 && crm == 4'd10) cache_op = MOP_NONE;
    else if (op2 == 3'd1 && crm == 4'd14) begin
      cache_op = MOP_CLN_INV_D_MVA; cache_uses = 1'b1;
    end else if (op2 == 3'd2 && crm == 4'd14) begin
      cache_op = MOP_CLN_INV_D_SW; cache_uses = 1'b1;
    end else if (op2 == 3'd3 && crm == 4'd14) cache_op = MOP_NONE;
    else if (op2 == 3'd4 && crm == 4'd10) cache_op = MOP_DRAIN_WB;
    else if (op2 == 3'd4 && crm == 4'd0) cache_op = MOP_DRAIN_WFI;
    else cache_known = 1'b0;
  end

  always_comb begin
    rdata_next  = '0;
    status_next = ST_OK;
    mop_next    = MOP_NONE;
    mopnd_next  = '0;
    if (!is_write) begin
      unique case (creg)
        CREG_ID: begin
          priority if (op2 == 3'd0) rdata_next = device_id;
          else if (op2 == 3'd1) rdata_next = CacheTypeVal;
          else if (op2 == 3'd2) rdata_next = '0;
          else status_next = ST_UNSUPPORTED;
        end
        CREG_CTRL: rdata_next = control_reg;
        CREG_TTB:  rdata_next = table_base_reg;
        CREG_DAC:  rdata_next = domain_access_reg;
        CREG_FSR: begin
          if (op2 == 3'd0) rdata_next = {{(WordW-FsrW){1'b0}}, fsr_reg};
          else status_next = ST_UNSUPPORTED;
        end
        CREG_FAR:  rdata_next = fault_address_reg;
        CREG_PID:  rdata_next = {process_id_reg, {PidShift{1'b0}}};
        default:   status_next = ST_UNSUPPORTED;
      endcase
    end else begin
      unique case (creg)
        CREG_CTRL, CREG_TTB, CREG_DAC, CREG_FAR, CREG_LOCK: status_next = ST_OK;
        CREG_FSR: begin
          if (op2 != 3'd0 && op2 != 3'd1) status_next = ST_UNSUPPORTED;
        end
        CREG_CACHE: begin
          if (!cache_known) status_next = ST_UNSUPPORTED;
          else begin
            mop_next   = cache_op;
            mopnd_next = cache_uses ? wval : '0;
          end
        end
        CREG_TLB: begin
          priority if (op2 == 3'd0 && tlb_crm_ok) mop_next = MOP_TLB_INV_ALL;
          else if (op2 == 3'd1 && tlb_crm_ok) begin
            mop_next   = MOP_TLB_INV_MVA;
            mopnd_next = wval;
          end else status_next = ST_UNSUPPORTED;
        end
        CREG_PID: begin
          if (op2 != 3'd0) status_next = ST_UNSUPPORTED;
        end
        default: status_next = ST_UNSUPPORTED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id         <= DeviceIdReset;
      control_reg       <= CtrlOnes;
      table_base_reg    <= '0;
      domain_access_reg <= DacReset;
      fsr_reg           <= '0;
      fault_address_reg <= '0;
      process_id_reg    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        device_id <= cfg_data;
      end
      if (accept && is_write) begin
        unique case (creg)
          CREG_CTRL: control_reg       <= (wval | CtrlOnes) & CtrlKeep;
          CREG_TTB:  table_base_reg    <= wval & TtbKeep;
          CREG_DAC:  domain_access_reg <= wval;
          CREG_FSR: begin
            if (op2 == 3'd0) fsr_reg <= wval[FsrW-1:0];
          end
          CREG_FAR:  fault_address_reg <= wval;
          CREG_PID: begin
            if (op2 == 3'd0) process_id_reg <= wval[PidShift +: PidW];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data     <= rdata_next;
      status        <= status_next;
      maint_op      <= mop_next;
      maint_operand <= mopnd_next;
    end
  end

  assign m_axis_tdata = {4'b0000, maint_operand, maint_op, read_data};
  assign m_axis_tuser = status;

endmodule

[rtl/cp15_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp15_checker
// Port-level checks for the coprocessor register file, bound to the top level.
// ----------------------------------------------------------------------------
module cp15_checker
  import cp15_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic [3:0] mop;

  assign mop = m_axis_tdata[35:32];

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_unsupported_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] == ST_UNSUPPORTED |->
      m_axis_tdata[31:0] == '0 && mop == MOP_NONE && m_axis_tdata[67:36] == '0)
    else $error("unsupported access carries data or command");

  a_maint_no_read: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && mop != MOP_NONE |-> m_axis_tdata[31:0] == '0)
    else $error("maintenance command with read data");

  a_no_operand: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (mop == MOP_NONE || mop == MOP_INV_IDC || mop == MOP_INV_IC
      || mop == MOP_INV_DC || mop == MOP_DRAIN_WB || mop == MOP_DRAIN_WFI
      || mop == MOP_TLB_INV_ALL) |-> m_axis_tdata[67:36] == '0)
    else $error("operand on command that takes none");

endmodule

bind cp15_system_control_registers_core cp15_checker u_cp15_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_cp15_system_control_registers_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cp15_system_control_registers_core
// Self-checking bench for the coprocessor register file. Directed and random
// MRC/MCR words go in on the input stream, while a scoreboard keeps its own
// copy of the registers and the main ID value. It predicts read data, status
// and maintenance commands, and compares every output word in order. Both
// stream sides stall at random outside one calm phase, and the main ID value
// is rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_cp15_system_control_registers_core;
  import cp15_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseWords    = 300;

  typedef struct packed {
    logic [31:0] rdata;
    status_t     st;
    maint_op_t   mop;
    logic [31:0] opnd;
  } access_result_t;

  class cp15_scoreboard;
    logic [31:0]    device_id;
    logic [31:0]    control;
    logic [31:0]    table_base;
    logic [31:0]    domain_access;
    logic [FsrW-1:0] fsr;
    logic [31:0]    fault_addr;
    logic [PidW-1:0] pid;
    access_result_t expected_q[$];
    int             errors;

    function new();
      device_id     = DeviceIdReset;
      control       = CtrlOnes;
      table_base    = '0;
      domain_access = DacReset;
      fsr           = '0;
      fault_addr    = '0;
      pid           = '0;
      errors        = 0;
    endfunction

    function void set_device_id(logic [31:0] value);
      device_id = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_access(req_type_t req, logic [31:0] instr, logic [31:0] wval);
      access_result_t r;
      creg_t          regn;
      logic [2:0]     op2;
      logic [3:0]     crm;
      logic           bad;
      regn = creg_t'(instr[19:16]);
      op2  = instr[7:5];
      crm  = instr[3:0];
      r    = '{rdata: '0, st: ST_OK, mop: MOP_NONE, opnd: '0};
      bad  = 1'b0;
      if (req == REQ_READ) begin
        case (regn)
          CREG_ID: begin
            case (op2)
              3'd0: r.rdata = device_id;
              3'd1: r.rdata = CacheTypeVal;
              3'd2: r.rdata = '0;
              default: bad = 1'b1;
            endcase
          end
          CREG_CTRL: r.rdata = (control | CtrlOnes) & CtrlKeep;
          CREG_TTB:  r.rdata = table_base & TtbKeep;
          CREG_DAC:  r.rdata = domain_access;
          CREG_FSR: begin
            if (op2 == 3'd0) r.rdata = {{(32-FsrW){1'b0}}, fsr};
            else bad = 1'b1;
          end
          CREG_FAR:  r.rdata = fault_addr;
          CREG_PID:  r.rdata = {pid, {PidShift{1'b0}}};
          default:   bad = 1'b1;
        endcase
        if (bad) r.rdata = '0;
      end else begin
        case (regn)
          CREG_CTRL: control = (wval | CtrlOnes) & CtrlKeep;
          CREG_TTB:  table_base = wval & TtbKeep;
          CREG_DAC:  domain_access = wval;
          CREG_FSR: begin
            if (op2 == 3'd0) fsr = wval[FsrW-1:0];
            else if (op2 != 3'd1) bad = 1'b1;
          end
          CREG_FAR:  fault_addr = wval;
          CREG_CACHE: begin
            case ({op2, crm})
              {3'd0, 4'd7}:  r.mop = MOP_INV_IDC;
              {3'd0, 4'd5}:  r.mop = MOP_INV_IC;
              {3'd1, 4'd5}:  begin r.mop = MOP_INV_I_MVA;     r.opnd = wval; end
              {3'd2, 4'd5}:  begin r.mop = MOP_INV_I_SW;      r.opnd = wval; end
              {3'd1, 4'd13}: ;
              {3'd0, 4'd6}:  r.mop = MOP_INV_DC;
              {3'd1, 4'd6}:  begin r.mop = MOP_INV_D_MVA;     r.opnd = wval; end
              {3'd2, 4'd6}:  begin r.mop = MOP_INV_D_SW;      r.opnd = wval; end
              {3'd1, 4'd10}: begin r.mop = MOP_CLN_D_MVA;     r.opnd = wval; end
              {3'd2, 4'd10}: begin r.mop = MOP_CLN_D_SW;      r.opnd = wval; end
              {3'd3, 4'd10}: ;
              {3'd1, 4'd14}: begin r.mop = MOP_CLN_INV_D_MVA; r.opnd = wval; end
              {3'd2, 4'd14}: begin r.mop = MOP_CLN_INV_D_SW;  r.opnd = wval; end
              {3'd3, 4'd14}: ;
              {3'd4, 4'd10}: r.mop = MOP_DRAIN_WB;
              {3'd4, 4'd0}:  r.mop = MOP_DRAIN_WFI;
              default:       bad = 1'b1;
            endcase
          end
          CREG_TLB: begin
            if (crm >= 4'd5 && crm <= 4'd7 && op2 == 3'd0) begin
              r.mop = MOP_TLB_INV_ALL;
            end else if (crm >= 4'd5 && crm <= 4'd7 && op2 == 3'd1) begin
              r.mop  = MOP_TLB_INV_MVA;
              r.opnd = wval;
            end else begin
              bad = 1'b1;
            end
          end
          CREG_LOCK: ;
          CREG_PID: begin
            if (op2 == 3'd0) pid = wval[PidShift +: PidW];
            else bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
      end
      r.st = bad ? ST_UNSUPPORTED : ST_OK;
      expected_q.push_back(r);
    endfunction

    function void check_result(access_result_t got);
      access_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual rdata=%h status=%0d",
                 $time, got.rdata, got.st);
        $display("%0t:   actual mop=%0d operand=%h", $time, got.mop, got.opnd);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got !== exp_r) begin
        errors++;
        $display("%0t: expected rdata=%h status=%0d mop=%0d operand=%h,",
                 $time, exp_r.rdata, exp_r.st, exp_r.mop, exp_r.opnd);
        $display("%0t:   actual rdata=%h status=%0d mop=%0d operand=%h",
                 $time, got.rdata, got.st, got.mop, got.opnd);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        calm = 1'b0;

  cp15_scoreboard sb = new();

  creg_t known_regs[9] = '{CREG_ID, CREG_CTRL, CREG_TTB, CREG_DAC, CREG_FSR,
                           CREG_FAR, CREG_CACHE, CREG_TLB, CREG_PID};
  logic [6:0] cache_pairs[16] = '{
    {3'd0, 4'd7},  {3'd0, 4'd5},  {3'd1, 4'd5},  {3'd2, 4'd5},
    {3'd1, 4'd13}, {3'd0, 4'd6},  {3'd1, 4'd6},  {3'd2, 4'd6},
    {3'd1, 4'd10}, {3'd2, 4'd10}, {3'd3, 4'd10}, {3'd1, 4'd14},
    {3'd2, 4'd14}, {3'd3, 4'd14}, {3'd4, 4'd10}, {3'd4, 4'd0}};

  cp15_system_control_registers_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result('{rdata: m_axis_tdata[31:0], st: status_t'(m_axis_tuser[0]),
                          mop: maint_op_t'(m_axis_tdata[35:32]),
                          opnd: m_axis_tdata[67:36]});
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_access(req_type_t'(s_axis_tuser[0]), s_axis_tdata[31:0],
                       s_axis_tdata[63:32]);
      end
      if (cfg_valid && cfg_ready) sb.set_device_id(cfg_data);
    end
  end

  function automatic logic [31:0] make_instr(logic [3:0] regn, logic [2:0] op2,
                                             logic [3:0] crm);
    logic [31:0] w;
    w        = $urandom;
    w[19:16] = regn;
    w[7:5]   = op2;
    w[3:0]   = crm;
    return w;
  endfunction

  function automatic logic [31:0] rand_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  task automatic send_access(req_type_t req, logic [31:0] instr, logic [31:0] wval);
    while (!calm && $urandom_range(0, 99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wval, instr};
    s_axis_tuser  <= req;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random_access();
    req_type_t  req;
    logic [3:0] regn;
    logic [2:0] op2;
    logic [3:0] crm;
    req  = req_type_t'($urandom_range(0, 1));
    regn = ($urandom_range(0, 99) < 75) ? known_regs[$urandom_range(0, 8)]
                                        : 4'($urandom_range(0, 15));
    op2  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                       : 3'($urandom_range(0, 2));
    crm  = 4'($urandom_range(0, 15));
    if (req == REQ_WRITE && regn == CREG_CACHE && $urandom_range(0, 9) < 8) begin
      {op2, crm} = cache_pairs[$urandom_range(0, 15)];
    end
    if (req == REQ_WRITE && regn == CREG_TLB && $urandom_range(0, 9) < 8) begin
      op2 = 3'($urandom_range(0, 1));
      crm = 4'($urandom_range(5, 7));
    end
    send_access(req, make_instr(regn, op2, crm), rand_word());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_device_id(logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_access(REQ_READ,  make_instr(CREG_ID, 3'd0, 4'd0), '1);
    send_access(REQ_READ,  make_instr(CREG_ID, 3'd1, 4'd0), '0);
    send_access(REQ_READ,  make_instr(CREG_ID, 3'd2, 4'd0), '0);
    send_access(REQ_READ,  make_instr(CREG_ID, 3'd3, 4'd0), '0);
    send_access(REQ_WRITE, make_instr(CREG_ID, 3'd0, 4'd0), '1);
    send_access(REQ_WRITE, make_instr(CREG_CTRL, 3'd7, 4'd15), '1);
    send_access(REQ_READ,  make_instr(CREG_CTRL, 3'd5, 4'd0), '0);
    send_access(REQ_WRITE, make_instr(CREG_CTRL, 3'd0, 4'd0), '0);
    send_access(REQ_READ,  make_instr(CREG_CTRL, 3'd0, 4'd0), '0);
    send_access(REQ_READ,  make_instr(CREG_DAC, 3'd0, 4'd0), '0);
    send_access(REQ_WRITE, make_instr(CREG_TTB, 3'd3, 4'd0), '1);
    send_access(REQ_READ,  make_instr(CREG_TTB, 3'd6, 4'd0), '0);
    send_access(REQ_WRITE, make_instr(CREG_FSR, 3'd0, 4'd0), '1);
    send_access(REQ_WRITE, make_instr(CREG_FSR, 3'd1, 4'd0), '0);
    send_access(REQ_WRITE, make_instr(CREG_FSR, 3'd2, 4'd0), '0);
    send_access(REQ_READ,  make_instr(CREG_FSR, 3'd0, 4'd0), '0);
    send_access(REQ_READ,  make_instr(CREG_FSR, 3'd1, 4'd0), '0);
    send_access(REQ_WRITE, make_instr(CREG_PID, 3'd0, 4'd0), '1);
    send_access(REQ_WRITE, make_instr(CREG_PID, 3'd1, 4'd0), '0);
    send_access(REQ_READ,  make_instr(CREG_PID, 3'd4, 4'd0), '0);
    send_access(REQ_READ,  make_instr(CREG_R4, 3'd0, 4'd0), '0);
    send_access(REQ_WRITE, make_instr(CREG_LOCK, 3'd0, 4'd0), '1);
    send_access(REQ_WRITE, make_instr(CREG_CACHE, 3'd1, 4'd13), '1);
    send_access(REQ_WRITE, make_instr(CREG_CACHE, 3'd5, 4'd10), '1);
    send_access(REQ_WRITE, make_instr(CREG_TLB, 3'd0, 4'd5), '1);
    send_access(REQ_WRITE, make_instr(CREG_TLB, 3'd1, 4'd7), '1);
    send_access(REQ_WRITE, make_instr(CREG_TLB, 3'd2, 4'd6), '1);
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    write_device_id('0);
    for (i = 0; i < PhaseWords; i++) send_random_access();
    write_device_id('1);
    calm <= 1'b1;
    for (i = 0; i < PhaseWords; i++) send_random_access();
    write_device_id($urandom);
    calm <= 1'b0;
    for (i = 0; i < PhaseWords; i++) send_random_access();
    write_device_id(DeviceIdReset);
    for (i = 0; i < PhaseWords; i++) send_random_access();
    drain();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
